FILE: src/mre_pkg.sv
// Shared types, codes and constants for the mini RISC instruction executor.
// Used by the controller, the datapath, the address wrap unit and the checker.
package mre_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned REG_IDX_W   = 4;
    localparam int unsigned REG_COUNT   = 16;
    localparam int unsigned LOAD_ADDR_W = 14;
    localparam int unsigned PC_OUT_W    = 14;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned ADDR_CALC_W = 33;

    localparam int unsigned OP_MSB  = 27;
    localparam int unsigned OP_LSB  = 24;
    localparam int unsigned RS_MSB  = 23;
    localparam int unsigned RS_LSB  = 20;
    localparam int unsigned RT_MSB  = 19;
    localparam int unsigned RT_LSB  = 16;
    localparam int unsigned RD_MSB  = 15;
    localparam int unsigned RD_LSB  = 12;
    localparam int unsigned IMM_MSB = 15;

    localparam logic [WORD_W-1:0] RF_RESET_VALUE = WORD_W'(-32'sd31768);

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_SLT  = 4'd2,
        OP_OR   = 4'd3,
        OP_NAND = 4'd4,
        OP_ADDI = 4'd5,
        OP_SLTI = 4'd6,
        OP_ORI  = 4'd7,
        OP_LUI  = 4'd8,
        OP_LW   = 4'd9,
        OP_SW   = 4'd10,
        OP_BEQ  = 4'd11,
        OP_JALR = 4'd12,
        OP_JUMP = 4'd13,
        OP_HALT = 4'd14,
        OP_NOP  = 4'd15
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_EXECUTED = 3'd1,
        ST_HALTED   = 3'd2,
        ST_NOP      = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FETCH,
        S_DECODE,
        S_WAIT_MOD,
        S_MEM_RD,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_load;
        logic latch_ir;
        logic decode;
        logic rd_data_addr;
        logic mod_take;
        logic load_word;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic halted;
        logic need_mod;
        logic is_lw;
        logic mod_done;
        logic out_free;
    } t_dp_stat;

    function automatic t_word rf_reset_value(logic [REG_IDX_W-1:0] idx);
        return (idx == '0) ? '0 : RF_RESET_VALUE;
    endfunction

endpackage

FILE: src/mini_risc_instruction_executor.sv
// Top level of the mini RISC instruction executor.
// Joins the controller (mre_ctrl) and the datapath (mre_datapath); uses mre_pkg.
//
// The input channel (i_valid, o_ready) carries one item per transfer. Mode 0
// writes i_load_data into the word memory at i_load_address; mode 1 executes
// the instruction at the program counter. Every item returns exactly one result
// on the output channel (o_valid, i_ready).
// One item is worked on at a time; o_ready is high only while the block waits
// for the next item. A load, store, lw, jump, jalr or taken branch passes
// through the address wrap, and a lw then reads the word memory; any other
// step goes from decode to commit, and a step after a halt is ignored and goes
// straight to commit. With a power-of-two MEM_WORDS the wrap registers the low
// bits; with any other depth it runs a reciprocal-multiply remainder instead.
// The output register holds its result until taken. While the receiver stalls,
// the next item can be taken and worked up to its commit, where it waits.
// Reset clears the program counter, halt flag and count, and resets registers;
// the word memory is not cleared and must be written before it is read.
module mini_risc_instruction_executor #(
    parameter int unsigned MEM_WORDS = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [mre_pkg::LOAD_ADDR_W-1:0]   i_load_address,
    input  logic [mre_pkg::WORD_W-1:0]        i_load_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mre_pkg::STATUS_W-1:0]      o_status,
    output logic [mre_pkg::PC_OUT_W-1:0]      o_pc_after,
    output logic                              o_reg_was_written,
    output logic [mre_pkg::REG_IDX_W-1:0]     o_reg_index,
    output logic signed [mre_pkg::WORD_W-1:0] o_reg_value,
    output logic                              o_mem_was_written,
    output logic [mre_pkg::WORD_W-1:0]        o_executed_count
);
    import mre_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    mre_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (i_mode),
        .i_load_address    (i_load_address),
        .i_load_data       (i_load_data),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_status          (o_status),
        .o_pc_after        (o_pc_after),
        .o_reg_was_written (o_reg_was_written),
        .o_reg_index       (o_reg_index),
        .o_reg_value       (o_reg_value),
        .o_mem_was_written (o_mem_was_written),
        .o_executed_count  (o_executed_count)
    );

endmodule

FILE: src/mre_addr_mod.sv
// Address wrap unit: reduces a signed 33-bit value modulo the memory depth.
// A power-of-two depth registers the low bits; any other depth works through the value
// in 11-bit digits with a reciprocal multiplication per digit. Depends on mre_pkg.
module mre_addr_mod #(
    parameter int unsigned MEM_WORDS = 16384,
    localparam int unsigned AW = $clog2(MEM_WORDS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mre_pkg::ADDR_CALC_W-1:0] i_value,
    output logic                            o_done,
    output logic [AW-1:0]                   o_result
);
    import mre_pkg::*;

    logic          r_done;
    logic [AW-1:0] r_result;

    assign o_done   = r_done;
    assign o_result = r_result;

    if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_pow2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_result <= i_value[AW-1:0];
            end
        end
    end else begin : g_recip
        localparam int unsigned DIG_W  = 11;
        localparam int unsigned DIGITS = (ADDR_CALC_W + DIG_W - 1) / DIG_W;
        localparam int unsigned XW     = DIGITS * DIG_W;
        localparam int unsigned NW     = AW + DIG_W;
        localparam int unsigned SH     = NW + AW;
        localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
        localparam logic [AW:0] MOD_V  = (AW + 1)'(MEM_WORDS);
        localparam logic [NW:0] RECIP  =
            (NW + 1)'(((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
        localparam logic [AW-1:0] WRAP_C = AW'((64'd1 << ADDR_CALC_W) % 64'(MEM_WORDS));

        logic             r_busy;
        logic             r_phase;
        logic [CNT_W-1:0] r_cnt;
        logic [XW-1:0]    r_x;
        logic [AW-1:0]    r_rem;
        logic             r_neg;
        logic [DIG_W:0]   r_q;
        logic [NW-1:0]    cur;
        logic [2*NW:0]    prod;
        logic [NW-1:0]    qm;
        logic [AW-1:0]    n_rem;
        logic [AW-1:0]    fixed;

        always_comb begin
            cur   = {r_rem, r_x[XW-1 -: DIG_W]};
            prod  = (2 * NW + 1)'(cur) * (2 * NW + 1)'(RECIP);
            qm    = NW'(r_q) * NW'(MOD_V);
            n_rem = AW'(cur - qm);
            if (!r_neg) begin
                fixed = r_rem;
            end else if (r_rem >= WRAP_C) begin
                fixed = r_rem - WRAP_C;
            end else begin
                fixed = r_rem + (MOD_V[AW-1:0] - WRAP_C);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy  <= 1'b0;
                r_done  <= 1'b0;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                    r_cnt   <= CNT_W'(DIGITS);
                end else if (r_busy && r_cnt != '0) begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end else if (r_busy) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_start) begin
                r_x   <= XW'(i_value);
                r_rem <= '0;
                r_neg <= i_value[ADDR_CALC_W-1];
            end else if (r_busy && r_cnt != '0) begin
                if (!r_phase) begin
                    r_q <= prod[SH +: DIG_W + 1];
                end else begin
                    r_x   <= {r_x[XW-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_rem <= n_rem;
                end
            end else if (r_busy) begin
                r_result <= fixed;
            end
        end
    end

endmodule

FILE: src/mre_ctrl.sv
// Controller state machine of the executor: sequences fetch, decode,
// address wrap, data access and commit. Depends on mre_pkg.
module mre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_mode,
    input  mre_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output mre_pkg::t_dp_cmd  o_cmd
);
    import mre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        n_state = S_LOAD;
                    end else if (i_stat.halted) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_LOAD:   n_state = S_WAIT_MOD;
            S_FETCH:  n_state = S_DECODE;
            S_DECODE: n_state = i_stat.need_mod ? S_WAIT_MOD : S_COMMIT;
            S_WAIT_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = i_stat.is_lw ? S_MEM_RD : S_COMMIT;
                end
            end
            S_MEM_RD: n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_LOAD:   o_cmd.start_load = 1'b1;
            S_FETCH:  o_cmd.latch_ir = 1'b1;
            S_DECODE: o_cmd.decode = 1'b1;
            S_WAIT_MOD: begin
                o_cmd.rd_data_addr = 1'b1;
                o_cmd.mod_take     = i_stat.mod_done;
            end
            S_MEM_RD: o_cmd.load_word = 1'b1;
            S_COMMIT: o_cmd.commit = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

FILE: src/mre_datapath.sv
// Datapath of the executor: word memory, register file, program counter,
// ALU, address wrap unit and output register. Depends on mre_pkg, mre_addr_mod.
module mre_datapath #(
    parameter int unsigned MEM_WORDS = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mre_pkg::t_dp_cmd                i_cmd,
    output mre_pkg::t_dp_stat               o_stat,
    input  logic                            i_mode,
    input  logic [mre_pkg::LOAD_ADDR_W-1:0] i_load_address,
    input  logic [mre_pkg::WORD_W-1:0]      i_load_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mre_pkg::STATUS_W-1:0]    o_status,
    output logic [mre_pkg::PC_OUT_W-1:0]    o_pc_after,
    output logic                            o_reg_was_written,
    output logic [mre_pkg::REG_IDX_W-1:0]   o_reg_index,
    output logic signed [mre_pkg::WORD_W-1:0] o_reg_value,
    output logic                            o_mem_was_written,
    output logic [mre_pkg::WORD_W-1:0]      o_executed_count
);
    import mre_pkg::*;

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    t_word r_mem [MEM_WORDS];
    t_word r_mem_q;
    t_word r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_valid;

    logic [AW-1:0]          r_pc;
    logic                   r_halted;
    t_word                  r_count;
    logic                   r_mode;
    logic                   r_ignored;
    logic [LOAD_ADDR_W-1:0] r_load_addr;
    t_word                  r_load_data;
    t_word                  r_ir;
    t_word                  r_a;
    t_word                  r_b;
    logic                   r_wreg;
    logic [REG_IDX_W-1:0]   r_widx;
    t_word                  r_wval;
    logic                   r_wmem;
    logic [AW-1:0]          r_next_pc;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [PC_OUT_W-1:0]    r_out_pc;
    logic                   r_out_wreg;
    logic [REG_IDX_W-1:0]   r_out_widx;
    t_word                  r_out_wval;
    logic                   r_out_wmem;
    t_word                  r_out_count;

    t_opcode                op;
    logic [REG_IDX_W-1:0]   rs;
    logic [REG_IDX_W-1:0]   rt;
    logic [REG_IDX_W-1:0]   rd;
    logic [IMM_MSB:0]       imm;
    t_word                  simm;
    t_word                  jalr_src;
    logic [AW-1:0]          next_seq;
    logic [REG_IDX_W-1:0]   ra_idx;
    logic [REG_IDX_W-1:0]   rb_idx;

    logic                   d_wreg;
    logic [REG_IDX_W-1:0]   d_widx;
    t_word                  d_wval;
    logic                   d_wmem;
    logic [AW-1:0]          d_next;
    logic                   d_need_mod;
    logic [ADDR_CALC_W-1:0] d_mod_val;

    logic                   mod_start;
    logic [ADDR_CALC_W-1:0] mod_val;
    logic                   mod_done;
    logic [AW-1:0]          mod_result;

    logic [AW-1:0]          mem_rd_addr;
    logic                   mem_we;
    t_word                  mem_wd;
    logic                   exec;
    t_status                status;
    logic [AW-1:0]          pc_after;
    t_word                  n_count;

    assign op     = t_opcode'(r_ir[OP_MSB:OP_LSB]);
    assign rs     = r_ir[RS_MSB:RS_LSB];
    assign rt     = r_ir[RT_MSB:RT_LSB];
    assign rd     = r_ir[RD_MSB:RD_LSB];
    assign imm    = r_ir[IMM_MSB:0];
    assign simm   = {{(WORD_W - IMM_MSB - 1){imm[IMM_MSB]}}, imm};
    assign next_seq = (r_pc == LAST_ADDR) ? '0 : r_pc + 1'b1;
    assign jalr_src = (rs == rt) ? WORD_W'(next_seq) : r_a;
    assign ra_idx = r_mem_q[RS_MSB:RS_LSB];
    assign rb_idx = r_mem_q[RT_MSB:RT_LSB];

    always_comb begin
        d_wreg     = 1'b0;
        d_widx     = '0;
        d_wval     = '0;
        d_wmem     = 1'b0;
        d_next     = next_seq;
        d_need_mod = 1'b0;
        d_mod_val  = {r_a[WORD_W-1], r_a} + {simm[WORD_W-1], simm};
        case (op)
            OP_ADD: begin
                d_wreg = 1'b1; d_widx = rd; d_wval = r_a + r_b;
            end
            OP_SUB: begin
                d_wreg = 1'b1; d_widx = rd; d_wval = r_a - r_b;
            end
            OP_SLT: begin
                d_wreg = 1'b1; d_widx = rd;
                d_wval = WORD_W'($signed(r_a) < $signed(r_b));
            end
            OP_OR: begin
                d_wreg = 1'b1; d_widx = rd; d_wval = r_a | r_b;
            end
            OP_NAND: begin
                d_wreg = 1'b1; d_widx = rd; d_wval = ~(r_a & r_b);
            end
            OP_ADDI: begin
                d_wreg = 1'b1; d_widx = rt; d_wval = r_a + simm;
            end
            OP_SLTI: begin
                d_wreg = 1'b1; d_widx = rt;
                d_wval = WORD_W'($signed(r_a) < $signed(simm));
            end
            OP_ORI: begin
                d_wreg = 1'b1; d_widx = rt; d_wval = r_a | WORD_W'(imm);
            end
            OP_LUI: begin
                d_wreg = 1'b1; d_widx = rt; d_wval = {imm, {(WORD_W - IMM_MSB - 1){1'b0}}};
            end
            OP_LW: begin
                d_wreg = 1'b1; d_widx = rt; d_need_mod = 1'b1;
            end
            OP_SW: begin
                d_wmem = 1'b1; d_need_mod = 1'b1;
            end
            OP_BEQ: begin
                if (r_a == r_b) begin
                    d_need_mod = 1'b1;
                    d_mod_val  = ADDR_CALC_W'(r_pc) + ADDR_CALC_W'(1)
                               + {simm[WORD_W-1], simm};
                end
            end
            OP_JALR: begin
                d_wreg     = 1'b1;
                d_widx     = rt;
                d_wval     = WORD_W'(next_seq);
                d_need_mod = 1'b1;
                d_mod_val  = {jalr_src[WORD_W-1], jalr_src};
            end
            OP_JUMP: begin
                d_need_mod = 1'b1;
                d_mod_val  = ADDR_CALC_W'(imm);
            end
            OP_HALT: d_next = next_seq;
            OP_NOP:  d_next = r_pc;
            default: d_next = next_seq;
        endcase
    end

    assign mod_start = i_cmd.start_load || (i_cmd.decode && d_need_mod);
    assign mod_val   = i_cmd.start_load ? ADDR_CALC_W'(r_load_addr) : d_mod_val;

    mre_addr_mod #(
        .MEM_WORDS (MEM_WORDS)
    ) u_addr_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_value  (mod_val),
        .o_done   (mod_done),
        .o_result (mod_result)
    );

    assign mem_rd_addr = i_cmd.rd_data_addr ? mod_result : r_pc;
    assign mem_we      = i_cmd.mod_take && (!r_mode || op == OP_SW);
    assign mem_wd      = r_mode ? r_b : r_load_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mod_result] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_ir) begin
            r_a <= r_rf_valid[ra_idx] ? r_rf[ra_idx] : rf_reset_value(ra_idx);
            r_b <= r_rf_valid[rb_idx] ? r_rf[rb_idx] : rf_reset_value(rb_idx);
        end
        if (i_cmd.commit && exec && r_wreg) begin
            r_rf[r_widx] <= r_wval;
        end
    end

    assign exec = r_mode && !r_ignored;

    always_comb begin
        if (!r_mode) begin
            status = ST_LOADED;
        end else if (r_ignored) begin
            status = ST_IGNORED;
        end else if (op == OP_HALT) begin
            status = ST_HALTED;
        end else if (op == OP_NOP) begin
            status = ST_NOP;
        end else begin
            status = ST_EXECUTED;
        end
    end

    assign pc_after = exec ? r_next_pc : r_pc;
    assign n_count  = r_count + WORD_W'(exec && op != OP_HALT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_count     <= '0;
            r_rf_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                if (exec) begin
                    r_pc <= r_next_pc;
                    if (op == OP_HALT) begin
                        r_halted <= 1'b1;
                    end
                    if (r_wreg) begin
                        r_rf_valid[r_widx] <= 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode      <= i_mode;
            r_ignored   <= i_mode && r_halted;
            r_load_addr <= i_load_address;
            r_load_data <= i_load_data;
            r_wreg      <= 1'b0;
            r_widx      <= '0;
            r_wval      <= '0;
            r_wmem      <= 1'b0;
        end
        if (i_cmd.latch_ir) begin
            r_ir <= r_mem_q;
        end
        if (i_cmd.decode) begin
            r_wreg    <= d_wreg;
            r_widx    <= d_widx;
            r_wval    <= d_wval;
            r_wmem    <= d_wmem;
            r_next_pc <= d_next;
        end
        if (i_cmd.mod_take && r_mode
                && (op == OP_BEQ || op == OP_JALR || op == OP_JUMP)) begin
            r_next_pc <= mod_result;
        end
        if (i_cmd.load_word) begin
            r_wval <= r_mem_q;
        end
        if (i_cmd.commit) begin
            r_out_status <= status;
            r_out_pc     <= PC_OUT_W'(pc_after);
            r_out_wreg   <= r_wreg;
            r_out_widx   <= r_widx;
            r_out_wval   <= r_wval;
            r_out_wmem   <= r_wmem;
            r_out_count  <= n_count;
        end
    end

    assign o_stat.halted   = r_halted;
    assign o_stat.need_mod = d_need_mod;
    assign o_stat.is_lw    = r_mode && op == OP_LW;
    assign o_stat.mod_done = mod_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_pc_after        = r_out_pc;
    assign o_reg_was_written = r_out_wreg;
    assign o_reg_index       = r_out_widx;
    assign o_reg_value       = $signed(r_out_wval);
    assign o_mem_was_written = r_out_wmem;
    assign o_executed_count  = r_out_count;

endmodule

FILE: src/mre_checker.sv
// Port-level checker for the mini RISC instruction executor and its bind.
// Depends on mre_pkg and the top level's port list.
module mre_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              i_mode,
    input logic [mre_pkg::LOAD_ADDR_W-1:0]   i_load_address,
    input logic [mre_pkg::WORD_W-1:0]        i_load_data,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [mre_pkg::STATUS_W-1:0]      o_status,
    input logic [mre_pkg::PC_OUT_W-1:0]      o_pc_after,
    input logic                              o_reg_was_written,
    input logic [mre_pkg::REG_IDX_W-1:0]     o_reg_index,
    input logic signed [mre_pkg::WORD_W-1:0] o_reg_value,
    input logic                              o_mem_was_written,
    input logic [mre_pkg::WORD_W-1:0]        o_executed_count
);
    import mre_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pc_after)
            && $stable(o_reg_value) && $stable(o_executed_count))
        else $error("Result changed while stalled.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("A second item was taken while one was in progress.");

    a_no_side_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_LOADED || o_status == ST_IGNORED
            || o_status == ST_HALTED) |-> !o_reg_was_written && !o_mem_was_written)
        else $error("Load, halt or ignored item reported a write.");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_was_written |-> o_reg_index == '0 && o_reg_value == '0)
        else $error("Register fields not zero without a register write.");

endmodule

bind mini_risc_instruction_executor mre_checker u_mre_checker (.*);

FILE: dv/tb_mini_risc_instruction_executor.sv
// Self-checking testbench for mini_risc_instruction_executor, with its own model of
// the register file, word memory, program counter, halt flag and count.
// Depends on mre_pkg for the opcode and status codes and on the block's top level.
`timescale 1ns / 1ps

module tb_mini_risc_instruction_executor;
    import mre_pkg::*;

    localparam longint MEM_DEPTH   = 16384;
    localparam int     ITEM_TARGET = 1640;
    localparam int     CYCLE_LIMIT = 400000;
    localparam t_word  REG_RESET   = -32'sd31768;

    typedef struct {
        t_status     status;
        logic [13:0] pc;
        logic        wreg;
        logic [3:0]  idx;
        t_word       val;
        logic        wmem;
        logic [31:0] count;
    } t_retire;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_mode = 1'b0;
    logic [13:0] i_load_address = '0;
    t_word       i_load_data = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [13:0] o_pc_after;
    logic        o_reg_was_written;
    logic [3:0]  o_reg_index;
    logic signed [31:0] o_reg_value;
    logic        o_mem_was_written;
    logic [31:0] o_executed_count;

    t_word       mem_image [MEM_DEPTH];
    bit          mem_valid [MEM_DEPTH];
    t_word       reg_image [16];
    logic [13:0] pc_model;
    bit          halted_model;
    logic [31:0] count_model;
    bit          op_seen [16];
    t_retire     retire_q [$];

    int  items_sent;
    int  results_seen;
    int  error_count;
    int  cycle_count;
    int  sink_hold;
    bit  src_idle_on;
    bit  snk_idle_on;

    mini_risc_instruction_executor DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_load_address    (i_load_address),
        .i_load_data       (i_load_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_pc_after        (o_pc_after),
        .o_reg_was_written (o_reg_was_written),
        .o_reg_index       (o_reg_index),
        .o_reg_value       (o_reg_value),
        .o_mem_was_written (o_mem_was_written),
        .o_executed_count  (o_executed_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, retire_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [13:0] wrap_address(input longint v);
        longint r;
        r = v % MEM_DEPTH;
        if (r < 0) r += MEM_DEPTH;
        return r[13:0];
    endfunction

    function automatic logic [13:0] data_address(input t_word ins);
        longint base;
        longint offs;
        base = $signed(reg_image[ins[23:20]]);
        offs = $signed(ins[15:0]);
        return wrap_address(base + offs);
    endfunction

    function automatic t_word r_word(input t_opcode op, input logic [3:0] rs,
                                     input logic [3:0] rt, input logic [3:0] rd);
        return {4'h0, op, rs, rt, rd, 12'h000};
    endfunction

    function automatic t_word i_word(input t_opcode op, input logic [3:0] rs,
                                     input logic [3:0] rt, input logic [15:0] imm);
        return {4'h0, op, rs, rt, imm};
    endfunction

    function automatic t_word rand_instr();
        t_opcode     op;
        logic [3:0]  rs;
        logic [3:0]  rt;
        logic [15:0] imm;
        op = t_opcode'($urandom_range(0, 15));
        if (op == OP_HALT) op = t_opcode'($urandom_range(0, 13));
        rs = 4'($urandom_range(0, 15));
        rt = 4'($urandom_range(0, 15));
        if (op == OP_BEQ && $urandom_range(0, 1) == 1) rt = rs;
        case ($urandom_range(0, 3))
            0: imm = 16'($urandom());
            1: imm = 16'($signed($urandom_range(0, 16)) - 8);
            2: begin
                case ($urandom_range(0, 3))
                    0: imm = 16'h0000;
                    1: imm = 16'h7FFF;
                    2: imm = 16'h8000;
                    default: imm = 16'hFFFF;
                endcase
            end
            default: imm = 16'($urandom_range(0, 64));
        endcase
        return {4'($urandom()), op, rs, rt, imm};
    endfunction

    task automatic reset_model();
        for (int i = 0; i < 16; i++) reg_image[i] = (i == 0) ? '0 : REG_RESET;
        for (int i = 0; i < MEM_DEPTH; i++) mem_valid[i] = 1'b0;
        pc_model = '0;
        halted_model = 1'b0;
        count_model = '0;
    endtask

    task automatic predict_retire(input logic mode, input logic [13:0] addr, input t_word data);
        t_retire     rec;
        t_word       ins;
        t_word       a;
        t_word       b;
        t_word       simm;
        logic [15:0] imm;
        logic [3:0]  rs;
        logic [3:0]  rt;
        logic [3:0]  rd;
        logic [13:0] nxt;
        t_opcode     op;
        rec.status = ST_EXECUTED;
        rec.wreg = 1'b0;
        rec.idx = '0;
        rec.val = '0;
        rec.wmem = 1'b0;
        if (!mode) begin
            mem_image[addr] = data;
            mem_valid[addr] = 1'b1;
            rec.status = ST_LOADED;
        end else if (halted_model) begin
            rec.status = ST_IGNORED;
        end else begin
            ins = mem_image[pc_model];
            op = t_opcode'(ins[27:24]);
            rs = ins[23:20];
            rt = ins[19:16];
            rd = ins[15:12];
            imm = ins[15:0];
            simm = {{16{imm[15]}}, imm};
            a = reg_image[rs];
            b = reg_image[rt];
            nxt = wrap_address(longint'(pc_model) + 1);
            op_seen[op] = 1'b1;
            case (op)
                OP_ADD: begin
                    rec.wreg = 1'b1; rec.idx = rd; rec.val = a + b;
                end
                OP_SUB: begin
                    rec.wreg = 1'b1; rec.idx = rd; rec.val = a - b;
                end
                OP_SLT: begin
                    rec.wreg = 1'b1; rec.idx = rd;
                    rec.val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                end
                OP_OR: begin
                    rec.wreg = 1'b1; rec.idx = rd; rec.val = a | b;
                end
                OP_NAND: begin
                    rec.wreg = 1'b1; rec.idx = rd; rec.val = ~(a & b);
                end
                OP_ADDI: begin
                    rec.wreg = 1'b1; rec.idx = rt; rec.val = a + simm;
                end
                OP_SLTI: begin
                    rec.wreg = 1'b1; rec.idx = rt;
                    rec.val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                OP_ORI: begin
                    rec.wreg = 1'b1; rec.idx = rt; rec.val = a | {16'h0000, imm};
                end
                OP_LUI: begin
                    rec.wreg = 1'b1; rec.idx = rt; rec.val = {imm, 16'h0000};
                end
                OP_LW: begin
                    rec.wreg = 1'b1; rec.idx = rt; rec.val = mem_image[data_address(ins)];
                end
                OP_SW: begin
                    rec.wmem = 1'b1;
                    mem_image[data_address(ins)] = b;
                    mem_valid[data_address(ins)] = 1'b1;
                end
                OP_BEQ: begin
                    if (a == b)
                        nxt = wrap_address(longint'(pc_model) + 1 + longint'($signed(simm)));
                end
                OP_JALR: begin
                    rec.wreg = 1'b1; rec.idx = rt; rec.val = {18'h0, nxt};
                end
                OP_JUMP: nxt = wrap_address(longint'(imm));
                OP_HALT: begin
                    rec.status = ST_HALTED;
                    halted_model = 1'b1;
                end
                default: begin
                    rec.status = ST_NOP;
                    nxt = pc_model;
                end
            endcase
            if (rec.wreg) reg_image[rec.idx] = rec.val;
            if (op == OP_JALR) nxt = wrap_address(longint'($signed(reg_image[rs])));
            pc_model = nxt;
            if (op != OP_HALT) count_model++;
        end
        rec.pc = pc_model;
        rec.count = count_model;
        retire_q.push_back(rec);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic mode, input logic [13:0] addr, input t_word data);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        predict_retire(mode, addr, data);
        i_valid <= 1'b1;
        i_mode <= mode;
        i_load_address <= addr;
        i_load_data <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // A load from a word that was never written is not allowed, so fill it first.
    task automatic step_at_pc();
        t_word       ins;
        logic [13:0] target;
        if (!halted_model) begin
            ins = mem_image[pc_model];
            if (ins[27:24] == OP_LW) begin
                target = data_address(ins);
                if (!mem_valid[target]) send_item(1'b0, target, $urandom());
            end
        end
        send_item(1'b1, 14'($urandom()), $urandom());
    endtask

    task automatic run_instr(input t_word ins);
        send_item(1'b0, pc_model, ins);
        step_at_pc();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40)
            $display("ERROR: %s got 0x%0h expected 0x%0h at result %0d",
                     what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin : result_check
        t_retire exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (retire_q.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_status), 32'd0);
            end else begin
                exp_r = retire_q.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch("status", 32'(o_status), 32'(exp_r.status));
                if (o_pc_after !== exp_r.pc)
                    report_mismatch("pc_after", 32'(o_pc_after), 32'(exp_r.pc));
                if (o_reg_was_written !== exp_r.wreg)
                    report_mismatch("reg_was_written", 32'(o_reg_was_written),
                                    32'(exp_r.wreg));
                if (o_reg_index !== exp_r.idx)
                    report_mismatch("reg_index", 32'(o_reg_index), 32'(exp_r.idx));
                if (o_reg_value !== exp_r.val)
                    report_mismatch("reg_value", o_reg_value, exp_r.val);
                if (o_mem_was_written !== exp_r.wmem)
                    report_mismatch("mem_was_written", 32'(o_mem_was_written),
                                    32'(exp_r.wmem));
                if (o_executed_count !== exp_r.count)
                    report_mismatch("executed_count", o_executed_count, exp_r.count);
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            i_ready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic test_alu_ops();
        run_instr(r_word(OP_ADD, 4'd1, 4'd2, 4'd3) | 32'hF000_0000);
        run_instr(r_word(OP_SUB, 4'd0, 4'd1, 4'd4));
        run_instr(r_word(OP_SLT, 4'd1, 4'd0, 4'd5));
        run_instr(r_word(OP_OR, 4'd1, 4'd3, 4'd6));
        run_instr(r_word(OP_NAND, 4'd1, 4'd1, 4'd0));
        run_instr(i_word(OP_ADDI, 4'd0, 4'd7, 16'h8000));
        run_instr(i_word(OP_SLTI, 4'd7, 4'd8, 16'h7FFF));
        run_instr(i_word(OP_ORI, 4'd1, 4'd9, 16'hFFFF) | 32'hA000_0000);
        run_instr(i_word(OP_LUI, 4'd0, 4'd10, 16'hFFFF));
    endtask

    task automatic test_memory_ops();
        run_instr(i_word(OP_SW, 4'd1, 4'd10, 16'hFFFF));
        run_instr(i_word(OP_LW, 4'd1, 4'd12, 16'hFFFF));
        run_instr(i_word(OP_LW, 4'd4, 4'd11, 16'h7FFF));
    endtask

    task automatic test_control_flow();
        run_instr(i_word(OP_BEQ, 4'd1, 4'd2, 16'hFFFD));
        run_instr(i_word(OP_JUMP, 4'd0, 4'd0, 16'hFFFF));
        run_instr(r_word(OP_NOP, 4'd5, 4'd6, 4'd7));
        run_instr(i_word(OP_JALR, 4'd13, 4'd13, 16'h0000));
        run_instr(i_word(OP_JALR, 4'd1, 4'd14, 16'h1234));
    endtask

    task automatic test_random_program();
        int pick;
        int phase_mark;
        phase_mark = items_sent;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - 200) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end else if (items_sent - phase_mark >= 150) begin
                phase_mark = items_sent;
                src_idle_on = $urandom_range(0, 3) != 0;
                snk_idle_on = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_instr(rand_instr());
            else if (pick < 90 && mem_valid[pc_model])
                step_at_pc();
            else
                send_item(1'b0, 14'($urandom()), $urandom());
        end
    endtask

    task automatic test_halt();
        run_instr(i_word(OP_HALT, 4'd3, 4'd4, 16'h5555));
        send_item(1'b1, 14'($urandom()), $urandom());
        send_item(1'b0, 14'h3FFF, 32'hFFFF_FFFF);
        send_item(1'b1, 14'($urandom()), $urandom());
    endtask

    initial begin
        int ops_covered;
        reset_model();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_alu_ops();
        test_memory_ops();
        test_control_flow();
        test_random_program();
        test_halt();

        i_valid <= 1'b0;
        while (retire_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        ops_covered = 0;
        for (int i = 0; i < 16; i++) ops_covered += op_seen[i];
        $display("Sent %0d items and checked %0d results in %0d cycles.",
                 items_sent, results_seen, cycle_count);
        $display("Executed %0d of 16 opcodes; %0d mismatches found.",
                 ops_covered, error_count);
        if (error_count == 0 && retire_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/mre_pkg.sv
src/mre_addr_mod.sv
src/mre_ctrl.sv
src/mre_datapath.sv
src/mini_risc_instruction_executor.sv
src/mre_checker.sv
dv/tb_mini_risc_instruction_executor.sv
